@@ src/rwlq_pkg.sv @@
// Shared types and codes for the reader-writer lock with wait queues.
package rwlq_pkg;

    localparam logic [2:0] ACT_RD_LOCK   = 3'd0;
    localparam logic [2:0] ACT_TRY_RD    = 3'd1;
    localparam logic [2:0] ACT_RD_UNLOCK = 3'd2;
    localparam logic [2:0] ACT_WR_LOCK   = 3'd3;
    localparam logic [2:0] ACT_TRY_WR    = 3'd4;
    localparam logic [2:0] ACT_WR_UNLOCK = 3'd5;

    localparam logic [2:0] ST_GRANTED  = 3'd0;
    localparam logic [2:0] ST_QUEUED   = 3'd1;
    localparam logic [2:0] ST_REFUSED  = 3'd2;
    localparam logic [2:0] ST_RELEASED = 3'd3;
    localparam logic [2:0] ST_FAIL     = 3'd4;

    localparam int HOLDERS_MAX = 31;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic walk;
    } t_ctrl_cmd;

    typedef struct packed {
        logic walk_start;
        logic walk_last;
    } t_dp_stat;

endpackage

@@ src/rwlq_ctrl.sv @@
// Controller state machine that sequences request execution and reader wake-up walks.
module rwlq_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  rwlq_pkg::t_dp_stat   i_stat,
    output logic                 busy,
    output rwlq_pkg::t_ctrl_cmd  o_cmd
);

    rwlq_pkg::t_state r_state;
    rwlq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rwlq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        o_cmd.walk    = 1'b0;
        busy          = 1'b1;
        case (r_state)
            rwlq_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = rwlq_pkg::S_EXEC;
                end
            end
            rwlq_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.walk_start ? rwlq_pkg::S_WALK : rwlq_pkg::S_IDLE;
            end
            rwlq_pkg::S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = rwlq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rwlq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ src/rwlq_dp.sv @@
// Datapath holding the lock state, both wait queues and the result registers.
module rwlq_dp #(
    parameter int TASKS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rwlq_pkg::t_ctrl_cmd  i_cmd,
    input  logic [2:0]           i_action,
    input  logic [3:0]           i_task_req,
    output rwlq_pkg::t_dp_stat   o_stat,
    output logic                 o_strobe,
    output logic [2:0]           o_status,
    output logic                 o_woken_valid,
    output logic [3:0]           o_woken_task,
    output logic                 o_woken_writer,
    output logic                 o_last
);

    localparam int IW  = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int CW  = $clog2(TASKS + 1);
    localparam int HW  = (CW > 5) ? CW : 5;
    localparam int SW  = CW + 1;

    logic [3:0]    rq_mem [TASKS];
    logic [3:0]    wq_mem [TASKS];

    logic [2:0]    r_act;
    logic [3:0]    r_task;
    logic [HW-1:0] r_holders, n_holders;
    logic          r_wholds, n_wholds;
    logic [IW-1:0] r_rhead, n_rhead;
    logic [IW-1:0] r_whead, n_whead;
    logic [CW-1:0] r_rcnt, n_rcnt;
    logic [CW-1:0] r_wcnt, n_wcnt;
    logic [3:0]    r_rrd;
    logic [3:0]    r_wrd;

    logic          r_strobe, n_strobe;
    logic [2:0]    r_status, n_status;
    logic          r_wv, n_wv;
    logic [3:0]    r_wt, n_wt;
    logic          r_ww, n_ww;
    logic          r_last, n_last;

    logic          rq_we, wq_we;
    logic [IW-1:0] rq_waddr, wq_waddr;
    logic [SW-1:0] rq_sum, wq_sum;

    function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx);
        return (idx == IW'(TASKS - 1)) ? '0 : idx + IW'(1);
    endfunction

    assign rq_sum   = SW'(r_rhead) + SW'(r_rcnt);
    assign wq_sum   = SW'(r_whead) + SW'(r_wcnt);
    assign rq_waddr = (rq_sum >= SW'(TASKS)) ? IW'(rq_sum - SW'(TASKS)) : IW'(rq_sum);
    assign wq_waddr = (wq_sum >= SW'(TASKS)) ? IW'(wq_sum - SW'(TASKS)) : IW'(wq_sum);

    assign o_stat.walk_start = (r_act == rwlq_pkg::ACT_WR_UNLOCK) && r_wholds &&
                               (r_wcnt == '0) && (r_rcnt > CW'(1));
    assign o_stat.walk_last  = (r_rcnt == CW'(1));

    always_comb begin
        n_holders = r_holders;
        n_wholds  = r_wholds;
        n_rhead   = r_rhead;
        n_whead   = r_whead;
        n_rcnt    = r_rcnt;
        n_wcnt    = r_wcnt;
        n_strobe  = 1'b0;
        n_status  = r_status;
        n_wv      = r_wv;
        n_wt      = r_wt;
        n_ww      = r_ww;
        n_last    = r_last;
        rq_we     = 1'b0;
        wq_we     = 1'b0;
        if (i_cmd.exec) begin
            n_strobe = 1'b1;
            n_status = rwlq_pkg::ST_FAIL;
            n_wv     = 1'b0;
            n_wt     = 4'd0;
            n_ww     = 1'b0;
            n_last   = 1'b1;
            case (r_act)
                rwlq_pkg::ACT_RD_LOCK, rwlq_pkg::ACT_TRY_RD: begin
                    if (r_wholds) begin
                        if (r_act == rwlq_pkg::ACT_TRY_RD) begin
                            n_status = rwlq_pkg::ST_REFUSED;
                        end else if (r_rcnt != CW'(TASKS)) begin
                            rq_we    = 1'b1;
                            n_rcnt   = r_rcnt + CW'(1);
                            n_status = rwlq_pkg::ST_QUEUED;
                        end
                    end else if (r_holders < HW'(rwlq_pkg::HOLDERS_MAX)) begin
                        n_holders = r_holders + HW'(1);
                        n_status  = rwlq_pkg::ST_GRANTED;
                    end
                end
                rwlq_pkg::ACT_RD_UNLOCK: begin
                    if (!r_wholds && (r_holders != '0)) begin
                        n_holders = r_holders - HW'(1);
                        n_status  = rwlq_pkg::ST_RELEASED;
                        if ((r_holders == HW'(1)) && (r_wcnt != '0)) begin
                            n_wholds = 1'b1;
                            n_whead  = next_idx(r_whead);
                            n_wcnt   = r_wcnt - CW'(1);
                            n_wv     = 1'b1;
                            n_wt     = r_wrd;
                            n_ww     = 1'b1;
                        end
                    end
                end
                rwlq_pkg::ACT_WR_LOCK, rwlq_pkg::ACT_TRY_WR: begin
                    if (!r_wholds && (r_holders == '0)) begin
                        n_wholds = 1'b1;
                        n_status = rwlq_pkg::ST_GRANTED;
                    end else if (r_act == rwlq_pkg::ACT_TRY_WR) begin
                        n_status = rwlq_pkg::ST_REFUSED;
                    end else if (r_wcnt != CW'(TASKS)) begin
                        wq_we    = 1'b1;
                        n_wcnt   = r_wcnt + CW'(1);
                        n_status = rwlq_pkg::ST_QUEUED;
                    end
                end
                rwlq_pkg::ACT_WR_UNLOCK: begin
                    if (r_wholds) begin
                        n_status = rwlq_pkg::ST_RELEASED;
                        if (r_wcnt != '0) begin
                            n_whead = next_idx(r_whead);
                            n_wcnt  = r_wcnt - CW'(1);
                            n_wv    = 1'b1;
                            n_wt    = r_wrd;
                            n_ww    = 1'b1;
                        end else begin
                            n_wholds = 1'b0;
                            if (r_rcnt != '0) begin
                                n_holders = HW'(r_rcnt);
                                n_rhead   = next_idx(r_rhead);
                                n_rcnt    = r_rcnt - CW'(1);
                                n_wv      = 1'b1;
                                n_wt      = r_rrd;
                                n_last    = (r_rcnt == CW'(1));
                            end
                        end
                    end
                end
                default: begin
                    n_status = rwlq_pkg::ST_FAIL;
                end
            endcase
        end else if (i_cmd.walk) begin
            n_strobe = 1'b1;
            n_status = rwlq_pkg::ST_RELEASED;
            n_rhead  = next_idx(r_rhead);
            n_rcnt   = r_rcnt - CW'(1);
            n_wv     = 1'b1;
            n_wt     = r_rrd;
            n_ww     = 1'b0;
            n_last   = (r_rcnt == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act  <= i_action;
            r_task <= i_task_req;
        end
        if (rq_we) begin
            rq_mem[rq_waddr] <= r_task;
        end
        if (wq_we) begin
            wq_mem[wq_waddr] <= r_task;
        end
        r_rrd    <= (rq_we && (rq_waddr == n_rhead)) ? r_task : rq_mem[n_rhead];
        r_wrd    <= (wq_we && (wq_waddr == n_whead)) ? r_task : wq_mem[n_whead];
        r_status <= n_status;
        r_wv     <= n_wv;
        r_wt     <= n_wt;
        r_ww     <= n_ww;
        r_last   <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holders <= '0;
            r_wholds  <= 1'b0;
            r_rhead   <= '0;
            r_whead   <= '0;
            r_rcnt    <= '0;
            r_wcnt    <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_holders <= n_holders;
            r_wholds  <= n_wholds;
            r_rhead   <= n_rhead;
            r_whead   <= n_whead;
            r_rcnt    <= n_rcnt;
            r_wcnt    <= n_wcnt;
            r_strobe  <= n_strobe;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_woken_valid  = r_wv;
    assign o_woken_task   = r_wt;
    assign o_woken_writer = r_ww;
    assign o_last         = r_last;

endmodule

@@ src/reader_writer_lock_queue.sv @@
// Top level of the reader-writer lock with FIFO reader and writer wait queues.
// A request is taken when start is high and busy is low; its first result beat is on
// o_strobe, registered from the execute state; a new request is taken only in idle.
// A write release that wakes N waiting readers gives N beats on consecutive cycles,
// and busy stays high through that walk; the receiver cannot stall.
// Synchronous active-low reset frees the lock and empties both queues at once.
module reader_writer_lock_queue #(
    parameter int TASKS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_action,
    input  logic [3:0] i_task_req,
    output logic       o_strobe,
    output logic [2:0] o_status,
    output logic       o_woken_valid,
    output logic [3:0] o_woken_task,
    output logic       o_woken_writer,
    output logic       o_last
);

    rwlq_pkg::t_ctrl_cmd cmd;
    rwlq_pkg::t_dp_stat  stat;

    rwlq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    rwlq_dp #(
        .TASKS (TASKS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_action       (i_action),
        .i_task_req     (i_task_req),
        .o_stat         (stat),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_woken_valid  (o_woken_valid),
        .o_woken_task   (o_woken_task),
        .o_woken_writer (o_woken_writer),
        .o_last         (o_last)
    );

endmodule

@@ src/rwlq_checker.sv @@
// Port-level checker for the reader-writer lock and its bind to the top level.
module rwlq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic [2:0] o_status,
    input logic       o_woken_valid,
    input logic [3:0] o_woken_task,
    input logic       o_woken_writer,
    input logic       o_last
);

    // Every accepted request produces a first result beat, registered from the execute state.
    a_first_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##2 o_strobe)
        else $error("no result beat two cycles after an accepted request");

    // A beat that is not the last one is followed at once by the next beat of the walk.
    a_walk_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe)
        else $error("reader wake-up walk broke off before its last beat");

    // Only a write release that wakes readers gives more than one beat.
    a_walk_beats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> o_woken_valid && !o_woken_writer &&
                                 (o_status == rwlq_pkg::ST_RELEASED))
        else $error("non-final beat is not a reader wake-up");

    // Woken fields are zero on a beat that hands the lock to nobody.
    a_woken_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_woken_valid |-> (o_woken_task == 4'd0) && !o_woken_writer)
        else $error("woken fields set on a beat without a wake-up");

endmodule

bind reader_writer_lock_queue rwlq_checker u_rwlq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .o_status       (o_status),
    .o_woken_valid  (o_woken_valid),
    .o_woken_task   (o_woken_task),
    .o_woken_writer (o_woken_writer),
    .o_last         (o_last)
);
